@@ design/fdct4_pkg.sv @@
package fdct4_pkg;

  // One residual row: four source and four prediction pixels.
  typedef struct packed {
    logic [7:0] src_pix0;
    logic [7:0] src_pix1;
    logic [7:0] src_pix2;
    logic [7:0] src_pix3;
    logic [7:0] ref_pix0;
    logic [7:0] ref_pix1;
    logic [7:0] ref_pix2;
    logic [7:0] ref_pix3;
  } row_t;

  // One coefficient row: vertical frequency freq_row, horizontal 0..3.
  typedef struct packed {
    logic signed [11:0] coef0;
    logic signed [11:0] coef1;
    logic signed [11:0] coef2;
    logic signed [11:0] coef3;
    logic [1:0]         freq_row;
    logic               last_row;
  } coef_row_t;

  localparam int RP_W = 14;
  localparam logic [1:0] LAST_ROW_IDX = 2'd3;

  // Row-pass result and a full 4x4 block of them, indexed [row][column].
  typedef logic signed [RP_W-1:0] rp_t;
  typedef rp_t [3:0] rp_row_t;
  typedef rp_row_t [3:0] blk_t;

  // Front stage status seen by the top level.
  typedef struct packed {
    logic busy;
    logic last;
  } front_stat_t;

  localparam int K_A = 2217;
  localparam int K_B = 5352;
  localparam int RND_ROW1 = 14500;
  localparam int RND_ROW3 = 7500;
  localparam int RND_COL1 = 12000;
  localparam int RND_COL3 = 51000;
  localparam int RND_COL_EVEN = 7;

endpackage

@@ design/fdct4_front.sv @@
module fdct4_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  row_valid,
  output logic                  row_ready,
  input  fdct4_pkg::row_t       row_data,
  output logic                  push,
  input  logic                  push_ready,
  output fdct4_pkg::blk_t       push_data,
  output fdct4_pkg::front_stat_t stat
);
  import fdct4_pkg::*;

  logic                     diff_valid;
  logic signed [8:0]        diff [4];
  logic [1:0]               diff_row;
  logic [1:0]               row_count;
  rp_row_t                  row_store [3];
  rp_row_t                  rp;
  logic                     advance;
  logic                     accept;

  logic signed [9:0]  e0, e1, f0, f1;
  logic signed [12:0] s0, s1, t0, t1;
  logic signed [26:0] m1, m3;

  assign advance   = diff_valid && ((diff_row != LAST_ROW_IDX) || push_ready);
  assign row_ready = !diff_valid || advance;
  assign accept    = row_valid && row_ready;

  // Row butterfly on the held differences.
  always_comb begin
    e0 = 10'(diff[0]) + 10'(diff[3]);
    e1 = 10'(diff[1]) + 10'(diff[2]);
    f0 = 10'(diff[1]) - 10'(diff[2]);
    f1 = 10'(diff[0]) - 10'(diff[3]);
    s0 = 13'(e0) <<< 3;
    s1 = 13'(e1) <<< 3;
    t0 = 13'(f0) <<< 3;
    t1 = 13'(f1) <<< 3;
    m1 = 27'(t0) * 27'(K_A) + 27'(t1) * 27'(K_B) + 27'(RND_ROW1);
    m3 = 27'(t1) * 27'(K_A) - 27'(t0) * 27'(K_B) + 27'(RND_ROW3);
    rp[0] = RP_W'(s0) + RP_W'(s1);
    rp[1] = RP_W'(m1 >>> 12);
    rp[2] = RP_W'(s0) - RP_W'(s1);
    rp[3] = RP_W'(m3 >>> 12);
  end

  assign push = advance && (diff_row == LAST_ROW_IDX);
  always_comb begin
    push_data[0] = row_store[0];
    push_data[1] = row_store[1];
    push_data[2] = row_store[2];
    push_data[3] = rp;
  end

  assign stat.busy = diff_valid;
  assign stat.last = (diff_row == LAST_ROW_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      row_count  <= 2'd0;
    end else if (accept) begin
      diff_valid <= 1'b1;
      row_count  <= row_count + 2'd1;
    end else if (advance) begin
      diff_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff[0]  <= 9'({1'b0, row_data.src_pix0}) - 9'({1'b0, row_data.ref_pix0});
      diff[1]  <= 9'({1'b0, row_data.src_pix1}) - 9'({1'b0, row_data.ref_pix1});
      diff[2]  <= 9'({1'b0, row_data.src_pix2}) - 9'({1'b0, row_data.ref_pix2});
      diff[3]  <= 9'({1'b0, row_data.src_pix3}) - 9'({1'b0, row_data.ref_pix3});
      diff_row <= row_count;
    end
    if (advance && (diff_row != LAST_ROW_IDX)) begin
      row_store[diff_row] <= rp;
    end
  end

endmodule

@@ design/fdct4_queue.sv @@
module fdct4_queue #(
  parameter int QDEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  fdct4_pkg::blk_t push_data,
  output logic            pop_valid,
  input  logic            pop,
  output fdct4_pkg::blk_t pop_data
);
  import fdct4_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  blk_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign push_ready = (count != CW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/fdct4_back.sv @@
module fdct4_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  blk_avail,
  output logic                  pop,
  input  fdct4_pkg::blk_t       blk_data,
  output logic                  coef_valid,
  input  logic                  coef_ready,
  output fdct4_pkg::coef_row_t  coef_data
);
  import fdct4_pkg::*;

  logic                blk_valid;
  logic [1:0]          phase;
  logic signed [14:0]  a0 [4], a1 [4], a2 [4], a3 [4];
  logic signed [14:0]  a0_next [4], a1_next [4], a2_next [4], a3_next [4];
  logic signed [11:0]  c [4];
  logic                load;

  logic signed [16:0]  even_sum [4];
  logic signed [15:0]  x [4], y [4];
  logic signed [29:0]  m [4];
  logic signed [13:0]  odd_c [4];

  assign load = blk_valid && (!coef_valid || coef_ready);
  assign pop  = blk_avail && (!blk_valid || (load && (phase == LAST_ROW_IDX)));

  // Column sums and differences of the block at the queue head.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a0_next[i] = 15'(blk_data[0][i]) + 15'(blk_data[3][i]);
      a1_next[i] = 15'(blk_data[1][i]) + 15'(blk_data[2][i]);
      a2_next[i] = 15'(blk_data[1][i]) - 15'(blk_data[2][i]);
      a3_next[i] = 15'(blk_data[0][i]) - 15'(blk_data[3][i]);
    end
  end

  // One vertical frequency per cycle while the output is not stalled, one lane per column.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      even_sum[i] = phase[1] ? (17'(a0[i]) - 17'(a1[i]) + 17'(RND_COL_EVEN))
                             : (17'(a0[i]) + 17'(a1[i]) + 17'(RND_COL_EVEN));
      x[i] = phase[1] ? 16'(a3[i]) : 16'(a2[i]);
      y[i] = phase[1] ? -16'(a2[i]) : 16'(a3[i]);
      m[i] = 30'(x[i]) * 30'(K_A) + 30'(y[i]) * 30'(K_B)
           + (phase[1] ? 30'(RND_COL3) : 30'(RND_COL1));
      odd_c[i] = 14'(m[i] >>> 16)
               + {13'd0, (!phase[1] && (a3[i] != '0))};
      c[i] = phase[0] ? 12'(odd_c[i]) : 12'(even_sum[i] >>> 4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid  <= 1'b0;
      phase      <= 2'd0;
      coef_valid <= 1'b0;
    end else begin
      if (pop) begin
        blk_valid <= 1'b1;
      end else if (load && (phase == LAST_ROW_IDX)) begin
        blk_valid <= 1'b0;
      end
      if (load) begin
        phase <= phase + 2'd1;
      end
      if (load) begin
        coef_valid <= 1'b1;
      end else if (coef_ready) begin
        coef_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a0 <= a0_next;
      a1 <= a1_next;
      a2 <= a2_next;
      a3 <= a3_next;
    end
    if (load) begin
      coef_data.coef0    <= c[0];
      coef_data.coef1    <= c[1];
      coef_data.coef2    <= c[2];
      coef_data.coef3    <= c[3];
      coef_data.freq_row <= phase;
      coef_data.last_row <= (phase == LAST_ROW_IDX);
    end
  end

endmodule

@@ design/forward_dct_4x4_residual.sv @@
// Channel | Signals                          | Beat
// --------+----------------------------------+---------------------------------
// rows in | row_valid, row_ready, row_data   | one residual row, src and pred
// coefs   | coef_valid, coef_ready, coef_data| one row of four coefficients
//
// A row beat can be taken every cycle while the queue has room; a block of four
// row beats yields four coefficient beats, one per cycle while coef_ready is high,
// so the sustained rate is one beat a cycle when neither side stalls. A block
// passes the difference, queue, column-sum and coefficient output registers in turn.
// Reset (rst, synchronous) empties the queue and restarts at row 0.
// A stalled coefficient side fills the QDEPTH-block queue, then holds row_ready low.
module forward_dct_4x4_residual #(
  parameter int QDEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 row_valid,
  output logic                 row_ready,
  input  fdct4_pkg::row_t      row_data,
  output logic                 coef_valid,
  input  logic                 coef_ready,
  output fdct4_pkg::coef_row_t coef_data
);
  import fdct4_pkg::*;

  // Block hand-off between the row pass and the column pass.
  logic        q_push;
  logic        q_ready;
  blk_t        q_wdata;
  logic        q_valid;
  logic        q_pop;
  blk_t        q_rdata;
  front_stat_t front_stat;

  // Front: take row beats, run the row butterfly, gather a block.
  fdct4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row_data   (row_data),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .stat       (front_stat)
  );

  // Queue: hold finished row-pass blocks until the column pass is free.
  fdct4_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  // Back: column pass, one vertical frequency per beat.
  fdct4_back u_back (
    .clk        (clk),
    .rst        (rst),
    .blk_avail  (q_valid),
    .pop        (q_pop),
    .blk_data   (q_rdata),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef_data  (coef_data)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("block pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("block popped from empty queue");

  // Row input stalls only behind a finished block waiting on a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !row_ready |-> (front_stat.busy && front_stat.last && !q_ready))
    else $error("row input stalled without a full queue");

endmodule

@@ test/tb_forward_dct_4x4_residual.sv @@
module tb_forward_dct_4x4_residual;
  import fdct4_pkg::*;

  // Transform constants, kept apart from the package so a slip there shows up.
  localparam int MUL_A       = 2217;
  localparam int MUL_B       = 5352;
  localparam int RND_H1      = 14500;
  localparam int RND_H3      = 7500;
  localparam int RND_V1      = 12000;
  localparam int RND_V3      = 51000;
  localparam int RND_V_EVEN  = 7;
  localparam int FINAL_ROW   = 3;
  localparam int PIX_MAX     = 255;
  localparam int RANDOM_BLKS = 112;
  localparam int DRAIN_EVERY = 29;
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum {STY_FULL, STY_NEAR, STY_EXTREME} row_style_e;
  typedef enum {
    PAT_ZERO, PAT_POS, PAT_NEG, PAT_CHECKER, PAT_QUADRANT, PAT_CORNERS
  } pattern_e;

  // One pending row beat; drain_first holds it back until every owed
  // coefficient row has come out.
  typedef struct {
    row_t row;
    bit   drain_first;
  } row_job_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      row_valid = 1'b0;
  logic      row_ready;
  row_t      row_data = '0;
  logic      coef_valid;
  logic      coef_ready = 1'b0;
  coef_row_t coef_data;

  row_job_t  row_jobs[$];
  coef_row_t coef_due[$];

  // Row-pass results of the block in flight, indexed row*4 + column.
  int row_pass[16];
  int row_idx = 0;

  // Counters shared between processes, apart from mismatches, move only by
  // nonblocking update, so every process reads the values from before the edge.
  int rows_planned = 0;
  int rows_taken   = 0;
  int owed_total   = 0;
  int seen_total   = 0;
  int owed_next;
  int mismatches   = 0;
  int cycle_count  = 0;
  int send_gap     = 0;
  int send_calm    = 0;
  int recv_gap     = 0;
  int recv_calm    = 0;

  forward_dct_4x4_residual u_top (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_data  (row_data),
    .coef_valid(coef_valid),
    .coef_ready(coef_ready),
    .coef_data (coef_data)
  );

  always #4 clk = ~clk;

  // Absorb one residual row: run the horizontal butterfly into the store and,
  // on the fourth row, run the vertical pass and queue four coefficient rows.
  // Return the number of coefficient rows that this row adds to those owed.
  function automatic int absorb_row(row_t r);
    int d[4];
    int s0, s1, t0, t1;
    int a0, a1, a2, a3;
    int c[4][4];
    coef_row_t res;
    d[0] = int'(r.src_pix0) - int'(r.ref_pix0);
    d[1] = int'(r.src_pix1) - int'(r.ref_pix1);
    d[2] = int'(r.src_pix2) - int'(r.ref_pix2);
    d[3] = int'(r.src_pix3) - int'(r.ref_pix3);
    s0 = (d[0] + d[3]) * 8;
    s1 = (d[1] + d[2]) * 8;
    t0 = (d[1] - d[2]) * 8;
    t1 = (d[0] - d[3]) * 8;
    row_pass[row_idx * 4 + 0] = s0 + s1;
    row_pass[row_idx * 4 + 1] = (t0 * MUL_A + t1 * MUL_B + RND_H1) >>> 12;
    row_pass[row_idx * 4 + 2] = s0 - s1;
    row_pass[row_idx * 4 + 3] = (t1 * MUL_A - t0 * MUL_B + RND_H3) >>> 12;
    if (row_idx != FINAL_ROW) begin
      row_idx++;
      return 0;
    end
    row_idx = 0;
    // Vertical pass down each column; the odd terms carry their own rounding
    // and coefficient 1 gets a nudge whenever its difference term is nonzero.
    for (int col = 0; col < 4; col++) begin
      a0 = row_pass[col] + row_pass[12 + col];
      a1 = row_pass[4 + col] + row_pass[8 + col];
      a2 = row_pass[4 + col] - row_pass[8 + col];
      a3 = row_pass[col] - row_pass[12 + col];
      c[0][col] = (a0 + a1 + RND_V_EVEN) >>> 4;
      c[1][col] = ((a2 * MUL_A + a3 * MUL_B + RND_V1) >>> 16) + (a3 != 0 ? 1 : 0);
      c[2][col] = (a0 - a1 + RND_V_EVEN) >>> 4;
      c[3][col] = (a3 * MUL_A - a2 * MUL_B + RND_V3) >>> 16;
    end
    for (int k = 0; k < 4; k++) begin
      res.coef0    = c[k][0][11:0];
      res.coef1    = c[k][1][11:0];
      res.coef2    = c[k][2][11:0];
      res.coef3    = c[k][3][11:0];
      res.freq_row = 2'(k);
      res.last_row = (k == FINAL_ROW);
      coef_due.push_back(res);
    end
    return 4;
  endfunction

  // Mostly short gaps, now and then a calm stretch with no idling at all.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic row_t pixels_to_row(logic [7:0] s[4], logic [7:0] p[4]);
    row_t r;
    r.src_pix0 = s[0];
    r.src_pix1 = s[1];
    r.src_pix2 = s[2];
    r.src_pix3 = s[3];
    r.ref_pix0 = p[0];
    r.ref_pix1 = p[1];
    r.ref_pix2 = p[2];
    r.ref_pix3 = p[3];
    return r;
  endfunction

  function automatic row_t make_row(row_style_e sty);
    logic [7:0] s[4];
    logic [7:0] p[4];
    int v;
    for (int c = 0; c < 4; c++) begin
      case (sty)
        STY_NEAR: begin
          // A good prediction: small residual around a random pixel.
          s[c] = $urandom_range(0, PIX_MAX);
          v = int'(s[c]) + int'($urandom_range(0, 16)) - 8;
          if (v < 0) v = 0;
          if (v > PIX_MAX) v = PIX_MAX;
          p[c] = v[7:0];
        end
        STY_EXTREME: begin
          s[c] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          p[c] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        default: begin
          s[c] = $urandom_range(0, PIX_MAX);
          p[c] = $urandom_range(0, PIX_MAX);
        end
      endcase
    end
    return pixels_to_row(s, p);
  endfunction

  // Residual of the directed blocks at row r, column c.
  function automatic int residual_at(pattern_e pat, int r, int c);
    case (pat)
      PAT_POS:      return PIX_MAX;
      PAT_NEG:      return -PIX_MAX;
      PAT_CHECKER:  return ((r + c) % 2 == 0) ? PIX_MAX : -PIX_MAX;
      PAT_QUADRANT: return ((r < 2) == (c < 2)) ? PIX_MAX : -PIX_MAX;
      PAT_CORNERS:  return (r == 0 && c == 0) ? PIX_MAX :
                           (r == 3 && c == 3) ? -PIX_MAX : 0;
      default:      return 0;
    endcase
  endfunction

  // Fill the row queue, release reset, then wait for the traffic to settle.
  initial begin
    row_job_t   job;
    logic [7:0] s[4];
    logic [7:0] p[4];
    int         d;
    row_style_e sty;
    int         pick;

    // Directed blocks: flat zero, full-scale positive and negative, the
    // highest frequencies both ways, quadrants of opposite sign, and a lone pixel in opposite corners.
    for (int pat = int'(PAT_ZERO); pat <= int'(PAT_CORNERS); pat++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          d = residual_at(pattern_e'(pat), r, c);
          s[c] = (d > 0) ? d[7:0] : 8'd0;
          p[c] = (d < 0) ? 8'(-d) : 8'd0;
        end
        job.row = pixels_to_row(s, p);
        job.drain_first = 1'b0;
        row_jobs.push_back(job);
      end
    end

    // Random blocks; every so often hold the next block until the pipe drains.
    for (int b = 0; b < RANDOM_BLKS; b++) begin
      pick = $urandom_range(0, 9);
      sty = (pick < 6) ? STY_FULL : (pick < 9) ? STY_NEAR : STY_EXTREME;
      for (int r = 0; r < 4; r++) begin
        job.row = make_row(($urandom_range(0, 7) == 0) ? STY_FULL : sty);
        job.drain_first = (r == 0) && (b % DRAIN_EVERY == 0);
        row_jobs.push_back(job);
      end
    end
    rows_planned = row_jobs.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (rows_taken < rows_planned || owed_total != seen_total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (coef_due.size() != 0) begin
      $error("%0d coefficient rows still expected", coef_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_forward_dct_4x4_residual: clean");
    end else begin
      $display("tb_forward_dct_4x4_residual: errors");
    end
    $finish;
  end

  // Row driver: predict on each accepted beat, hold valid and payload while
  // the block stalls, and idle for the drawn gap before the next beat.
  always @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      send_gap = draw_gap(send_calm);
    end else begin
      owed_next = owed_total;
      if (row_valid && row_ready) begin
        owed_next = owed_total + absorb_row(row_data);
        owed_total <= owed_next;
        rows_taken <= rows_taken + 1;
        send_gap = draw_gap(send_calm);
      end
      if (!row_valid || row_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          row_valid <= 1'b0;
        end else if (row_jobs.size() > 0 &&
                     !(row_jobs[0].drain_first && owed_next != seen_total)) begin
          row_data  <= row_jobs[0].row;
          row_valid <= 1'b1;
          row_jobs.delete(0);
        end else begin
          row_valid <= 1'b0;
        end
      end
    end
  end

  // Coefficient monitor: compare each beat with the oldest expectation, then
  // drop ready for the drawn stall.
  always @(posedge clk) begin
    if (rst) begin
      coef_ready <= 1'b0;
      recv_gap = draw_gap(recv_calm);
    end else begin
      if (coef_valid && coef_ready) begin
        seen_total <= seen_total + 1;
        if (coef_due.size() == 0) begin
          $error("coefficient row beat with nothing expected");
          mismatches++;
        end else begin
          if (coef_data.coef0 !== coef_due[0].coef0) begin
            $error("coef0: expected %0d, got %0d", coef_due[0].coef0, coef_data.coef0);
            mismatches++;
          end
          if (coef_data.coef1 !== coef_due[0].coef1) begin
            $error("coef1: expected %0d, got %0d", coef_due[0].coef1, coef_data.coef1);
            mismatches++;
          end
          if (coef_data.coef2 !== coef_due[0].coef2) begin
            $error("coef2: expected %0d, got %0d", coef_due[0].coef2, coef_data.coef2);
            mismatches++;
          end
          if (coef_data.coef3 !== coef_due[0].coef3) begin
            $error("coef3: expected %0d, got %0d", coef_due[0].coef3, coef_data.coef3);
            mismatches++;
          end
          if (coef_data.freq_row !== coef_due[0].freq_row) begin
            $error("freq_row: expected %0d, got %0d",
                   coef_due[0].freq_row, coef_data.freq_row);
            mismatches++;
          end
          if (coef_data.last_row !== coef_due[0].last_row) begin
            $error("last_row: expected %0d, got %0d",
                   coef_due[0].last_row, coef_data.last_row);
            mismatches++;
          end
          coef_due.delete(0);
        end
        recv_gap = draw_gap(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        coef_ready <= 1'b0;
      end else begin
        coef_ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_forward_dct_4x4_residual: errors");
      $finish;
    end
  end

endmodule
